// ----- hdl/seg7_pkg.sv -----
// Shared types, constants and lookup functions for the seven-segment scan driver.
package seg7_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int DIGIT_W     = 4;
  localparam int IDX_W       = 2;
  localparam int OP_W        = 2;
  localparam int VALUE_W     = 16;
  localparam int RAW_W       = 8;
  localparam int CODE_W      = 8;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CODE_W-1:0] SEL_FIRST = 8'h80;
  localparam logic [CODE_W-1:0] DOT_CODE  = 8'h01;
  localparam logic [IDX_W-1:0]  DOT_INDEX = 2'd2;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIGIT_COUNT - 1);

  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

  // Reciprocal constants: x/1000 = (x*67109)>>26 for 16-bit x,
  // x/100 = (x*41)>>12 for x < 1000, x/10 = (x*103)>>10 for x < 100.
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int          SHIFT_1000 = 26;
  localparam logic [5:0]  RECIP_100  = 6'd41;
  localparam int          SHIFT_100  = 12;
  localparam logic [6:0]  RECIP_10   = 7'd103;
  localparam int          SHIFT_10   = 10;

  typedef enum logic [OP_W-1:0] {
    OP_SET_VALUE  = 2'd0,
    OP_SET_DIGITS = 2'd1,
    OP_SCAN       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_kind_t;

  typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    cmd_kind_t kind;
    digits_t   digits;
  } seg7_cmd_t;

  function automatic logic [DIGIT_W-1:0] clamp9(input logic [RAW_W-1:0] raw);
    logic [DIGIT_W-1:0] res;
    if (raw > RAW_W'(MAX_DIGIT)) begin
      res = MAX_DIGIT;
    end else begin
      res = raw[DIGIT_W-1:0];
    end
    return res;
  endfunction

  // Segments a..g in bits 7..1, bit 0 is the decimal point.
  function automatic logic [CODE_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [CODE_W-1:0] res;
    case (digit)
      4'd0:    res = 8'hFC;
      4'd1:    res = 8'h60;
      4'd2:    res = 8'hDA;
      4'd3:    res = 8'hF2;
      4'd4:    res = 8'h66;
      4'd5:    res = 8'hB6;
      4'd6:    res = 8'hBE;
      4'd7:    res = 8'hE0;
      4'd8:    res = 8'hFE;
      4'd9:    res = 8'hF6;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ----- hdl/seg7_if.sv -----
// Valid/ready channel interfaces for the input items and the scan results.
interface seg7_in_if;
  logic                         valid;
  logic                         ready;
  logic [seg7_pkg::OP_W-1:0]    op;
  logic [seg7_pkg::VALUE_W-1:0] value_tenths;
  logic [seg7_pkg::RAW_W-1:0]   digit_a;
  logic [seg7_pkg::RAW_W-1:0]   digit_b;
  logic [seg7_pkg::RAW_W-1:0]   digit_c;
  logic [seg7_pkg::RAW_W-1:0]   digit_d;

  modport source (output valid, op, value_tenths, digit_a, digit_b, digit_c, digit_d,
                  input ready);
  modport sink (input valid, op, value_tenths, digit_a, digit_b, digit_c, digit_d,
                output ready);
endinterface

interface seg7_out_if;
  logic                        valid;
  logic                        ready;
  logic [seg7_pkg::CODE_W-1:0] select_code;
  logic [seg7_pkg::CODE_W-1:0] segment_code;
  logic [seg7_pkg::IDX_W-1:0]  shown_index;

  modport source (output valid, select_code, segment_code, shown_index, input ready);
  modport sink (input valid, select_code, segment_code, shown_index, output ready);
endinterface

// ----- hdl/seg7_front.sv -----
// Front end: accepts beats, drops unused ops, splits values into decimal digits.
module seg7_front (
  input  logic                clk,
  input  logic                rst_n,
  seg7_in_if.sink             in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output seg7_pkg::seg7_cmd_t push_cmd
);
  import seg7_pkg::*;

  logic adv;
  logic take;

  // stage 1: thousands quotient
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_is_val_r;
  cmd_kind_t          s1_kind_r;
  logic [VALUE_W-1:0] s1_v_r;
  logic [6:0]         s1_q_r;
  digits_t            s1_dig_r;
  logic [32:0]        q_prod;

  // stage 2: remainder below 1000
  logic          s2_valid_r;
  logic          s2_is_val_r;
  cmd_kind_t     s2_kind_r;
  logic [9:0]    s2_rest_r;
  digits_t       s2_dig_r, s2_dig_nxt;
  logic [16:0]   rest_full;

  // stage 3: remainder below 100
  logic          s3_valid_r;
  logic          s3_is_val_r;
  cmd_kind_t     s3_kind_r;
  logic [6:0]    s3_r2_r;
  digits_t       s3_dig_r, s3_dig_nxt;
  logic [15:0]   h_prod;
  logic [9:0]    r2_full;

  logic [13:0]   t_prod;
  logic [6:0]    u_full;
  logic [DIGIT_W-1:0] tens;

  // The whole pipe moves together; it holds only when the last stage can't push.
  assign adv         = !s3_valid_r || push_ready;
  assign in_ch.ready = adv;
  assign take        = in_ch.valid && adv && (in_ch.op != OP_NONE);
  assign s1_valid_nxt = take;

  assign q_prod = 33'(in_ch.value_tenths) * 33'(RECIP_1000);

  always_comb begin
    rest_full  = {1'b0, s1_v_r} - (17'(s1_q_r) * 17'(1000));
    s2_dig_nxt = s1_dig_r;
    if (s1_is_val_r) begin
      s2_dig_nxt[0] = (s1_q_r > 7'(MAX_DIGIT)) ? MAX_DIGIT : s1_q_r[DIGIT_W-1:0];
    end
  end

  always_comb begin
    h_prod     = 16'(s2_rest_r) * 16'(RECIP_100);
    s3_dig_nxt = s2_dig_r;
    if (s2_is_val_r) begin
      s3_dig_nxt[1] = h_prod[SHIFT_100 +: DIGIT_W];
    end
    r2_full = s2_rest_r - (10'(h_prod[SHIFT_100 +: DIGIT_W]) * 10'(100));
  end

  always_comb begin
    t_prod          = 14'(s3_r2_r) * 14'(RECIP_10);
    tens            = t_prod[SHIFT_10 +: DIGIT_W];
    u_full          = s3_r2_r - (7'(tens) * 7'(10));
    push_cmd.kind   = s3_kind_r;
    push_cmd.digits = s3_dig_r;
    if (s3_is_val_r) begin
      push_cmd.digits[2] = tens;
      push_cmd.digits[3] = u_full[DIGIT_W-1:0];
    end
  end

  assign push_valid = s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_is_val_r <= (in_ch.op == OP_SET_VALUE);
      s1_kind_r   <= (in_ch.op == OP_SCAN) ? CMD_SCAN : CMD_LOAD;
      s1_v_r      <= in_ch.value_tenths;
      s1_q_r      <= q_prod[SHIFT_1000 +: 7];
      s1_dig_r[0] <= clamp9(in_ch.digit_a);
      s1_dig_r[1] <= clamp9(in_ch.digit_b);
      s1_dig_r[2] <= clamp9(in_ch.digit_c);
      s1_dig_r[3] <= clamp9(in_ch.digit_d);

      s2_is_val_r <= s1_is_val_r;
      s2_kind_r   <= s1_kind_r;
      s2_rest_r   <= rest_full[9:0];
      s2_dig_r    <= s2_dig_nxt;

      s3_is_val_r <= s2_is_val_r;
      s3_kind_r   <= s2_kind_r;
      s3_r2_r     <= r2_full[6:0];
      s3_dig_r    <= s3_dig_nxt;
    end
  end

endmodule

// ----- hdl/seg7_queue.sv -----
// Short command queue between the front end and the scan back end.
module seg7_queue #(
  parameter int DEPTH = seg7_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  seg7_pkg::seg7_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output seg7_pkg::seg7_cmd_t pop_cmd
);
  import seg7_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  seg7_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");
`endif

endmodule

// ----- hdl/seg7_back.sv -----
// Back end: holds the digits and scan index, produces one result beat per scan tick.
module seg7_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  seg7_pkg::seg7_cmd_t pop_cmd,
  seg7_out_if.source          out_ch
);
  import seg7_pkg::*;

  digits_t            digits_r, digits_nxt;
  logic [IDX_W-1:0]   scan_index_r, scan_index_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  sel_r, sel_nxt;
  logic [CODE_W-1:0]  seg_r, seg_nxt;
  logic [IDX_W-1:0]   shown_r, shown_nxt;
  logic               out_free;
  logic               do_pop, do_scan;

  // Loads never wait; a scan waits only for room in the output register.
  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = (pop_cmd.kind == CMD_LOAD) || out_free;
  assign do_pop    = pop_valid && pop_ready;
  assign do_scan   = do_pop && (pop_cmd.kind == CMD_SCAN);

  always_comb begin
    digits_nxt     = digits_r;
    scan_index_nxt = scan_index_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    sel_nxt        = sel_r;
    seg_nxt        = seg_r;
    shown_nxt      = shown_r;
    if (do_pop && (pop_cmd.kind == CMD_LOAD)) begin
      digits_nxt = pop_cmd.digits;
    end
    if (do_scan) begin
      out_valid_nxt  = 1'b1;
      sel_nxt        = SEL_FIRST >> scan_index_r;
      seg_nxt        = seg_of(digits_r[scan_index_r]);
      if (scan_index_r == DOT_INDEX) begin
        seg_nxt = seg_nxt | DOT_CODE;
      end
      shown_nxt      = scan_index_r;
      scan_index_nxt = (scan_index_r == LAST_IDX) ? '0 : scan_index_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r     <= '0;
      scan_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      digits_r     <= digits_nxt;
      scan_index_r <= scan_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    seg_r   <= seg_nxt;
    shown_r <= shown_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.select_code  = sel_r;
  assign out_ch.segment_code = seg_r;
  assign out_ch.shown_index  = shown_r;

`ifndef SYNTHESIS
  a_sel_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sel_r == (SEL_FIRST >> shown_r)))
    else $error("select code does not match shown index");

  a_dot_only_third: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (seg_r[0] == (shown_r == DOT_INDEX)))
    else $error("decimal point on wrong digit");

  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    do_scan |=> (shown_r == $past(scan_index_r)) &&
                (scan_index_r == (($past(scan_index_r) == LAST_IDX) ?
                                  '0 : $past(scan_index_r) + 1'b1)))
    else $error("scan index did not advance with the tick");
`endif

endmodule

// ----- hdl/four_digit_7seg_scan_driver.sv -----
// Top level of the four-digit multiplexed seven-segment scan driver.
//
// in_ch is a valid/ready channel of commands: op 0 loads a value given in
// tenths (split into thousands, hundreds, tens and units, thousands capped
// at 9), op 1 loads four raw digits clamped to 9, op 2 is a scan tick, op 3
// is taken and ignored. out_ch carries one beat per scan tick: the one-hot
// digit select, the segment pattern (decimal point on the third digit) and
// the index lit; the index then wraps after the fourth digit.
// A beat is accepted on every cycle while nothing stalls. The front end is a
// three-stage constant-divide pipeline; commands then pass a short queue to
// the back end, where each scan result is registered before it leaves on out_ch.
// Loads and ticks take effect strictly in arrival order.
// Reset clears the digits to zero, the scan index to zero and all pipeline,
// queue and output valid state. When out_ch stalls, the result stays in the
// output register, queued loads drain until the next tick reaches the back
// end, and in_ch backs off once the queue is full and the last front stage
// holds a command.
module four_digit_7seg_scan_driver #(
  parameter int QUEUE_DEPTH = seg7_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  seg7_in_if.sink    in_ch,
  seg7_out_if.source out_ch
);
  import seg7_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  seg7_cmd_t push_cmd, pop_cmd;

  seg7_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  seg7_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  seg7_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule
